FILE: hw/rtl/etr_pkg.sv
// ----------------------------------------------------------------------------
// etr_pkg
// Shared types, constants and the CRC-32 byte update for the table read
// responder.
// ----------------------------------------------------------------------------
package etr_pkg;

	localparam logic [3:0]  POS_LAST  = 4'd12;
	localparam logic [7:0]  HDR_ZERO  = 8'h00;
	localparam logic [7:0]  HDR_LEN   = 8'h07;
	localparam logic [7:0]  HDR_CMD   = 8'h72;
	localparam logic [7:0]  STATUS_OK = 8'h00;
	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_STATUS,
		ST_DATA_RD,
		ST_DATA_EMIT,
		ST_CRC3,
		ST_CRC2,
		ST_CRC1,
		ST_CRC0
	} state_t;

	typedef enum logic [2:0] {
		SEL_LEN_HI,
		SEL_LEN_LO,
		SEL_STATUS,
		SEL_DATA,
		SEL_CRC3,
		SEL_CRC2,
		SEL_CRC1,
		SEL_CRC0
	} sel_t;

	typedef struct packed {
		logic take;
		logic check;
		logic emit;
		sel_t sel;
		logic rd;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic frame_ok;
		logic out_free;
		logic size_zero;
		logic data_last;
	} sts_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/etr_ram.sv
// ----------------------------------------------------------------------------
// etr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module etr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/etr_ctrl.sv
// ----------------------------------------------------------------------------
// etr_ctrl
// Controller that accepts input beats, checks a finished frame and steps
// through the bytes of a reply.
// ----------------------------------------------------------------------------
module etr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  etr_pkg::sts_t sts,
	output etr_pkg::cmd_t cmd
);

	import etr_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_LEN_HI;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.frame_end) begin
						state_n = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_n   = sts.frame_ok ? ST_LEN_HI : ST_IDLE;
			end
			ST_LEN_HI: begin
				cmd.sel = SEL_LEN_HI;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_LEN_LO;
				end
			end
			ST_LEN_LO: begin
				cmd.sel = SEL_LEN_LO;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_STATUS;
				end
			end
			ST_STATUS: begin
				cmd.sel = SEL_STATUS;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = sts.size_zero ? ST_CRC3 : ST_DATA_RD;
				end
			end
			ST_DATA_RD: begin
				cmd.rd  = 1'b1;
				state_n = ST_DATA_EMIT;
			end
			ST_DATA_EMIT: begin
				cmd.sel = SEL_DATA;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = sts.data_last ? ST_CRC3 : ST_DATA_RD;
				end
			end
			ST_CRC3: begin
				cmd.sel = SEL_CRC3;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_CRC2;
				end
			end
			ST_CRC2: begin
				cmd.sel = SEL_CRC2;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_CRC1;
				end
			end
			ST_CRC1: begin
				cmd.sel = SEL_CRC1;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_CRC0;
				end
			end
			ST_CRC0: begin
				cmd.sel = SEL_CRC0;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/etr_datapath.sv
// ----------------------------------------------------------------------------
// etr_datapath
// Frame assembly, CRC-32 accumulation, table storage and the output
// register of the table read responder.
// ----------------------------------------------------------------------------
module etr_datapath #(
	parameter int TABLE_BYTES = 56
) (
	input  logic          clk,
	input  logic          arst_n,
	input  etr_pkg::cmd_t cmd,
	output etr_pkg::sts_t sts,
	input  logic          action,
	input  logic [7:0]    data_byte,
	input  logic [5:0]    table_index,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [7:0]    tx_byte,
	output logic          last_byte
);

	import etr_pkg::*;

	localparam int AW = $clog2(TABLE_BYTES);
	localparam int CW = $clog2(TABLE_BYTES + 1);

	logic [3:0]             pos_q;
	logic [31:0]            crc_q;
	logic [15:0]            ofs_q;
	logic [15:0]            size_q;
	logic [31:0]            got_q;
	logic [CW-1:0]          len_q;
	logic [CW-1:0]          cnt_q;
	logic                   zero_q;
	logic                   vld_rd_q;
	logic [TABLE_BYTES-1:0] vld_q;
	logic                   out_valid_q;
	logic [7:0]             tx_byte_q;
	logic                   last_q;

	logic                   rx_take;
	logic                   wr_take;
	logic [3:0]             pos_n;
	logic [16:0]            end_w;
	logic [15:0]            room_w;
	logic [CW-1:0]          clip_w;
	logic [CW-1:0]          idx_w;
	logic [CW:0]            addr_sum;
	logic                   zero_w;
	logic [AW-1:0]          raddr;
	logic [7:0]             rdata;
	logic [7:0]             data_w;
	logic [15:0]            len16;
	logic [31:0]            fin_w;
	logic [7:0]             byte_w;

	assign rx_take = cmd.take && !action;
	assign wr_take = cmd.take && action && (table_index < 6'(TABLE_BYTES));

	always_comb begin
		case (pos_q)
			4'd0:    pos_n = (data_byte == HDR_ZERO) ? 4'd1 : 4'd0;
			4'd1:    pos_n = (data_byte == HDR_LEN)  ? 4'd2 : 4'd0;
			4'd2:    pos_n = (data_byte == HDR_CMD)  ? 4'd3 : 4'd0;
			4'd3:    pos_n = (data_byte == HDR_ZERO) ? 4'd4 : 4'd0;
			4'd4:    pos_n = (data_byte == HDR_LEN)  ? 4'd5 : 4'd0;
			POS_LAST: pos_n = 4'd0;
			default: pos_n = pos_q + 4'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
		end else if (rx_take) begin
			pos_q <= pos_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_take) begin
			vld_q[table_index[AW-1:0]] <= 1'b1;
		end
	end

	assign end_w  = {1'b0, ofs_q} + {1'b0, size_q};
	assign room_w = 16'(TABLE_BYTES) - ofs_q;
	assign clip_w = (end_w > 17'(TABLE_BYTES)) ? room_w[CW-1:0] : size_q[CW-1:0];

	assign idx_w    = cnt_q ^ {{(CW - 1){1'b0}}, 1'b1};
	assign addr_sum = {1'b0, ofs_q[CW-1:0]} + {1'b0, idx_w};
	assign zero_w   = (cnt_q | {{(CW - 1){1'b0}}, 1'b1}) >= len_q;
	assign raddr    = zero_w ? '0 : addr_sum[AW-1:0];

	etr_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_BYTES)
	) u_table (
		.clk  (clk),
		.we   (wr_take),
		.waddr(table_index[AW-1:0]),
		.wdata(data_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign data_w = (zero_q || !vld_rd_q) ? 8'h00 : rdata;
	assign len16  = 16'(len_q) + 16'd1;
	assign fin_w  = ~crc_q;

	always_comb begin
		case (cmd.sel)
			SEL_LEN_HI: byte_w = len16[15:8];
			SEL_LEN_LO: byte_w = len16[7:0];
			SEL_STATUS: byte_w = STATUS_OK;
			SEL_DATA:   byte_w = data_w;
			SEL_CRC3:   byte_w = fin_w[31:24];
			SEL_CRC2:   byte_w = fin_w[23:16];
			SEL_CRC1:   byte_w = fin_w[15:8];
			SEL_CRC0:   byte_w = fin_w[7:0];
			default:    byte_w = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			case (pos_q)
				4'd2:    crc_q <= crc_byte(CRC_INIT, data_byte);
				4'd3, 4'd4, 4'd7, 4'd8: crc_q <= crc_byte(crc_q, data_byte);
				4'd5: begin
					crc_q       <= crc_byte(crc_q, data_byte);
					ofs_q[15:8] <= data_byte;
				end
				4'd6: begin
					crc_q      <= crc_byte(crc_q, data_byte);
					ofs_q[7:0] <= data_byte;
				end
				4'd9, 4'd10, 4'd11, POS_LAST: got_q <= {got_q[23:0], data_byte};
				default: got_q <= got_q;
			endcase
			if (pos_q == 4'd7) begin
				size_q[15:8] <= data_byte;
			end
			if (pos_q == 4'd8) begin
				size_q[7:0] <= data_byte;
			end
		end
		if (cmd.check) begin
			len_q <= clip_w;
			cnt_q <= '0;
		end
		if (cmd.rd) begin
			zero_q   <= zero_w;
			vld_rd_q <= vld_q[raddr];
		end
		if (cmd.emit && cmd.sel == SEL_STATUS) begin
			crc_q <= crc_byte(CRC_INIT, STATUS_OK);
		end
		if (cmd.emit && cmd.sel == SEL_DATA) begin
			crc_q <= crc_byte(crc_q, data_w);
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.emit) begin
			tx_byte_q <= byte_w;
			last_q    <= (cmd.sel == SEL_CRC0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.frame_end = !action && (pos_q == POS_LAST);
	assign sts.frame_ok  = (fin_w == got_q) && (ofs_q < 16'(TABLE_BYTES));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.size_zero = (len_q == '0);
	assign sts.data_last = ((cnt_q + CW'(1)) == len_q);

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign last_byte = last_q;

endmodule

FILE: hw/rtl/ecu_table_read_responder.sv
// ----------------------------------------------------------------------------
// ecu_table_read_responder
// Serial table read command parser and reply generator with CRC-32 framing.
// ----------------------------------------------------------------------------
// Each input beat is either a received link byte or a write of one table
// byte, and is taken while no reply or frame check is in progress. The beat
// that completes a 13-byte command is followed by a check of its CRC and
// offset. A reply then leaves the output register at one byte per cycle,
// while the output is not stalled, for the length, status and CRC bytes.
// Each table data byte passes through a read state before its emit state,
// as the read of the table RAM is registered. No input beat is taken until
// the last reply byte is in the output register.
module ecu_table_read_responder #(
	parameter int TABLE_BYTES = 56
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] data_byte,
	input  logic [5:0] table_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       last_byte
);

	import etr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	etr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	etr_datapath #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.data_byte  (data_byte),
		.table_index(table_index),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.tx_byte    (tx_byte),
		.last_byte  (last_byte)
	);

endmodule

FILE: hw/rtl/etr_checker.sv
// ----------------------------------------------------------------------------
// etr_checker
// Port level checks of the table read responder, bound to the top level.
// ----------------------------------------------------------------------------
module etr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       action,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] tx_byte,
	input logic       last_byte
);

	// A stalled output beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last_byte))
		else $error("output beat changed while stalled");

	// No input is taken while a reply still has bytes to come.
	a_no_in_mid_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_byte |-> !in_ready)
		else $error("input ready in the middle of a reply");

	// A table write produces no output beat.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action && !out_valid |=> !out_valid)
		else $error("output beat after a table write");

endmodule

bind ecu_table_read_responder etr_checker u_etr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.action     (action),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.tx_byte    (tx_byte),
	.last_byte  (last_byte)
);
